// File: rtl/core/glyph_border_point_emitter_assert.svh
// Assertion macros shared by the border point emitter RTL.
// Each macro expands to one labelled concurrent assertion on the given clock and reset.
`ifndef GLYPH_BORDER_POINT_EMITTER_ASSERT_SVH
`define GLYPH_BORDER_POINT_EMITTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GBPE_ASSERT_SAME(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GBPE_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gbpe_pkg.sv
// Shared types and constants of the glyph border point emitter.
// No dependencies; every other RTL file of the block but the assertion macro header refers to this package.
`default_nettype none

package gbpe_pkg;

    localparam int MAX_HEIGHT    = 64;
    localparam int MAX_WIDTH     = 64;
    localparam int BORDER_LAYERS = 20;

    // Row index, clamped height, column count and emitter step widths.
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int STEP_W   = $clog2(BORDER_LAYERS + 1);

    // Field widths fixed by the interface.
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_SIZE_W    = 7;
    localparam int ALPHA_W       = 8;
    localparam int POINT_X_W     = 6;
    localparam int POINT_Y_W     = 7;
    localparam int POINT_DEPTH_W = 5;
    localparam int POINT_INDEX_W = 16;

    localparam int OUT_FIELDS_W = POINT_X_W + POINT_Y_W + POINT_DEPTH_W + POINT_INDEX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int SIZE_RESET_VAL = 64;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  =
        WIDTH_W'((SIZE_RESET_VAL > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET_VAL);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET =
        HEIGHT_W'((SIZE_RESET_VAL > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET_VAL);
    localparam logic [ALPHA_W-1:0]  THRESHOLD_RESET = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 2'd0,
        CFG_IMAGE_HEIGHT    = 2'd1,
        CFG_ALPHA_THRESHOLD = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    // Active configuration as seen by the datapath, plus the scan restart strobe.
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [ALPHA_W-1:0]  threshold;
        logic                restart;
    } cfg_t;

    // One judged pixel handed from the judging stage to the point emitter.
    typedef struct packed {
        logic [POINT_X_W-1:0] x;
        logic [POINT_Y_W-1:0] y;
        logic                 opaque;
        logic                 border;
        logic                 restart;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/core/glyph_border_point_emitter.sv
// Top level of the glyph border point emitter: configuration, judging stage and point emitter.
// Depends on gbpe_pkg, gbpe_cfg, gbpe_judge and gbpe_emitter.
//
//  Channel   Direction  Payload                                         Transaction
//  s_axis    in         tdata: pixel_alpha; tuser: opcode               tvalid & tready
//  m_axis    out        tdata: point_x, point_y, point_depth, point_index;
//                       tlast: last point of one pixel                  tvalid & tready
//  cfg       in         cfg_index, cfg_data                             cfg_we
//
// An input transaction is judged in the cycle it is accepted and lands in a one-entry job
// register; the emitter then issues one point per cycle, while m_axis accepts, from its output register.
// A border pixel yields 21 points, an inner opaque pixel one, and a transparent,
// ignored or first-column item none, so the rate is set by the single result channel.
// Input is accepted while earlier points are still draining, as long as the job register is
// free or being emptied; a stalled m_axis holds the output register and, in turn, the input.
// Reset (rst_n, asynchronous, active low) clears the counters and the handshake state and
// loads the register reset values; there is no clearing pass.
`default_nettype none

module glyph_border_point_emitter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [gbpe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbpe_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Pixel stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [gbpe_pkg::ALPHA_W-1:0]       s_axis_tdata,  // [7:0] pixel_alpha
    input  wire logic                               s_axis_tuser,  // [0] opcode

    // Point stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [5:0] point_x, [12:6] point_y, [17:13] point_depth, [33:18] point_index, rest zero
    output logic [gbpe_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast
);

    gbpe_pkg::cfg_t cfg;
    gbpe_pkg::job_t job;
    logic           job_valid;
    logic           job_ready;

    // Register writes also restart the scan; the user must make them only while the block is idle (unenforced).
    gbpe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Each pixel is judged one column late, against both column delay lines.
    gbpe_judge u_judge (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .job_valid     (job_valid),
        .job           (job),
        .job_ready     (job_ready)
    );

    // Expands each judged opaque pixel into its depth layers (border pixels only) plus the final depth-zero point.
    gbpe_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .job_valid     (job_valid),
        .job           (job),
        .job_ready     (job_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/gbpe_cfg.sv
// Configuration registers of the glyph border point emitter, with size clamping.
// Depends on gbpe_pkg.
`default_nettype none

module gbpe_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_data,
    output gbpe_pkg::cfg_t                      cfg
);

    logic [gbpe_pkg::WIDTH_W-1:0]    width_reg,  width_next;
    logic [gbpe_pkg::HEIGHT_W-1:0]   height_reg, height_next;
    logic [gbpe_pkg::ALPHA_W-1:0]    thr_reg,    thr_next;
    logic [gbpe_pkg::CFG_SIZE_W-1:0] size_val;
    logic                            known_index;

    assign size_val = cfg_data[gbpe_pkg::CFG_SIZE_W-1:0];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        thr_next    = thr_reg;
        known_index = 1'b0;
        case (gbpe_pkg::cfg_index_t'(cfg_index))
            gbpe_pkg::CFG_IMAGE_WIDTH:
            begin
                known_index = 1'b1;
                if (size_val == '0)
                    width_next = gbpe_pkg::WIDTH_W'(1);
                else if (int'(size_val) > gbpe_pkg::MAX_WIDTH)
                    width_next = gbpe_pkg::WIDTH_W'(gbpe_pkg::MAX_WIDTH);
                else
                    width_next = gbpe_pkg::WIDTH_W'(size_val);
            end
            gbpe_pkg::CFG_IMAGE_HEIGHT:
            begin
                known_index = 1'b1;
                if (size_val == '0)
                    height_next = gbpe_pkg::HEIGHT_W'(1);
                else if (int'(size_val) > gbpe_pkg::MAX_HEIGHT)
                    height_next = gbpe_pkg::HEIGHT_W'(gbpe_pkg::MAX_HEIGHT);
                else
                    height_next = gbpe_pkg::HEIGHT_W'(size_val);
            end
            gbpe_pkg::CFG_ALPHA_THRESHOLD:
            begin
                known_index = 1'b1;
                thr_next    = cfg_data[gbpe_pkg::ALPHA_W-1:0];
            end
            default:
            begin
                known_index = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gbpe_pkg::WIDTH_RESET;
            height_reg <= gbpe_pkg::HEIGHT_RESET;
            thr_reg    <= gbpe_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thr_reg    <= thr_next;
        end
    end

    // A write to any known register restarts the scan in the same cycle.
    assign cfg.width     = width_reg;
    assign cfg.height    = height_reg;
    assign cfg.threshold = thr_reg;
    assign cfg.restart   = cfg_we && known_index;

endmodule

`default_nettype wire

// File: rtl/core/gbpe_judge.sv
// Input stage: thresholds pixels, keeps the two column delay lines and judges one pixel per item.
// Depends on gbpe_pkg.
`default_nettype none

module gbpe_judge (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  gbpe_pkg::cfg_t                    cfg,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [gbpe_pkg::ALPHA_W-1:0] s_axis_tdata,
    input  wire logic                         s_axis_tuser,
    output logic                              job_valid,
    output gbpe_pkg::job_t                    job,
    input  wire logic                         job_ready
);

    // Delay lines of length height: entry 0 holds the row being judged.
    logic [gbpe_pkg::MAX_HEIGHT-1:0] mid_reg,  mid_next;
    logic [gbpe_pkg::MAX_HEIGHT-1:0] prev_reg, prev_next;
    logic                            up_reg;

    logic [gbpe_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [gbpe_pkg::WIDTH_W-1:0]  col_reg, col_next;
    logic                          job_valid_reg, job_valid_next;
    gbpe_pkg::job_t                job_reg, job_calc;

    logic                          in_take;
    logic                          is_flush;
    logic                          px;
    logic                          ignored;
    logic                          judged;
    logic                          right;
    logic                          border;
    logic                          row_wrap;
    logic                          restart;
    logic                          job_make;
    logic [gbpe_pkg::WIDTH_W-1:0]  x_full;
    logic [gbpe_pkg::WIDTH_W-1:0]  x_plus1;
    logic [gbpe_pkg::HEIGHT_W-1:0] row_plus;
    logic [gbpe_pkg::ROW_W-1:0]    h_last;

    assign s_axis_tready = !job_valid_reg || job_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign is_flush = (gbpe_pkg::opcode_t'(s_axis_tuser) == gbpe_pkg::OP_FLUSH);
    assign px       = (s_axis_tdata >= cfg.threshold);
    assign ignored  = is_flush ? (col_reg < cfg.width) : (col_reg >= cfg.width);
    assign judged   = !ignored && (is_flush || (col_reg != '0));
    assign right    = is_flush ? 1'b0 : px;
    assign x_full   = is_flush ? (cfg.width - gbpe_pkg::WIDTH_W'(1))
                               : (col_reg - gbpe_pkg::WIDTH_W'(1));
    assign x_plus1  = is_flush ? cfg.width : col_reg;
    assign row_plus = gbpe_pkg::HEIGHT_W'(row_reg) + gbpe_pkg::HEIGHT_W'(1);
    assign row_wrap = (row_plus >= cfg.height);
    assign h_last   = gbpe_pkg::ROW_W'(cfg.height - gbpe_pkg::HEIGHT_W'(1));

    // Edge of the image, or any of the four neighbours transparent.
    assign border = (x_full == '0) || !prev_reg[0] || (row_reg == '0) || !up_reg ||
                    (x_plus1 >= cfg.width) || !right || row_wrap || !mid_reg[1];

    assign restart  = is_flush && !ignored && row_wrap;
    assign job_make = (judged && mid_reg[0]) || restart;

    always_comb
    begin
        job_calc.x       = gbpe_pkg::POINT_X_W'(x_full);
        job_calc.y       = gbpe_pkg::POINT_Y_W'(cfg.height - gbpe_pkg::HEIGHT_W'(row_reg));
        job_calc.opaque  = judged && mid_reg[0];
        job_calc.border  = border;
        job_calc.restart = restart;
    end

    always_comb
    begin
        mid_next          = mid_reg >> 1;
        mid_next[h_last]  = is_flush ? 1'b0 : px;
        prev_next         = prev_reg >> 1;
        prev_next[h_last] = mid_reg[0];
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg.restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (in_take && !ignored)
        begin
            if (row_wrap)
            begin
                row_next = '0;
                col_next = is_flush ? '0 : (col_reg + gbpe_pkg::WIDTH_W'(1));
            end
            else
            begin
                row_next = row_plus[gbpe_pkg::ROW_W-1:0];
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (in_take)
            job_valid_next = job_make;
        else if (job_ready)
            job_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // Column bits and the job payload need no reset: the scan never reads stale rows.
    always_ff @(posedge clk)
    begin
        if (in_take && !ignored)
        begin
            mid_reg  <= mid_next;
            prev_reg <= prev_next;
            up_reg   <= mid_reg[0];
        end
        if (in_take)
            job_reg <= job_calc;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

// File: rtl/core/gbpe_emitter.sv
// Point emitter: expands each judged pixel into its points and drives the output register.
// Depends on gbpe_pkg and the assertion macro header.
`default_nettype none

`include "glyph_border_point_emitter_assert.svh"

module gbpe_emitter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  gbpe_pkg::cfg_t                         cfg,
    input  wire logic                              job_valid,
    input  gbpe_pkg::job_t                         job,
    output logic                                   job_ready,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [gbpe_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tlast
);

    logic                                  active_reg, active_next;
    gbpe_pkg::job_t                        cur_reg;
    logic [gbpe_pkg::STEP_W-1:0]           step_reg, step_next;
    logic [gbpe_pkg::POINT_INDEX_W-1:0]    pc_reg, pc_next;

    logic                                  out_valid_reg, out_valid_next;
    logic [gbpe_pkg::POINT_X_W-1:0]        out_x_reg;
    logic [gbpe_pkg::POINT_Y_W-1:0]        out_y_reg;
    logic [gbpe_pkg::POINT_DEPTH_W-1:0]    out_d_reg;
    logic [gbpe_pkg::POINT_INDEX_W-1:0]    out_idx_reg;
    logic                                  out_last_reg;

    logic                                  out_free;
    logic                                  load;
    logic                                  pt_last;
    logic                                  finishing;
    logic                                  job_take;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign load      = active_reg && out_free;
    assign pt_last   = (step_reg == gbpe_pkg::STEP_W'(gbpe_pkg::BORDER_LAYERS));
    assign finishing = load && pt_last;
    assign job_ready = !active_reg || finishing;
    assign job_take  = job_valid && job_ready;

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        pc_next     = pc_reg;
        if (finishing)
            active_next = 1'b0;
        if (load && !pt_last)
            step_next = step_reg + gbpe_pkg::STEP_W'(1);
        if (load)
            pc_next = (finishing && cur_reg.restart) ? '0
                                                     : (pc_reg + gbpe_pkg::POINT_INDEX_W'(1));
        if (job_take)
        begin
            if (job.opaque)
            begin
                active_next = 1'b1;
                step_next   = job.border ? '0 : gbpe_pkg::STEP_W'(gbpe_pkg::BORDER_LAYERS);
            end
            else if (job.restart)
            begin
                pc_next = '0;
            end
        end
        if (cfg.restart)
            pc_next = '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take && job.opaque)
            cur_reg <= job;
        if (load)
        begin
            out_x_reg    <= cur_reg.x;
            out_y_reg    <= cur_reg.y;
            out_d_reg    <= pt_last ? '0 : gbpe_pkg::POINT_DEPTH_W'(step_reg);
            out_idx_reg  <= pc_reg;
            out_last_reg <= pt_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = gbpe_pkg::OUT_TDATA_W'({out_idx_reg, out_d_reg, out_y_reg, out_x_reg});

    `GBPE_ASSERT_SAME(a_step_in_range, clk, rst_n, active_reg,
        (int'(step_reg) <= gbpe_pkg::BORDER_LAYERS), "emitter step beyond final point")
    `GBPE_ASSERT_NEXT(a_stay_active, clk, rst_n, load && !pt_last,
        active_reg, "emitter went idle before the final point of a pixel")
    `GBPE_ASSERT_NEXT(a_done_idle, clk, rst_n, finishing && !job_take,
        !active_reg, "emitter still active after the final point")
    `GBPE_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg.restart,
        (pc_reg == '0), "point number not cleared by a register write")

endmodule

`default_nettype wire
